FILE: hdl/normalized_kronecker_product_assert.svh
// Assertion helpers for the normalized Kronecker product block.
// Both expect clk and rst in scope.
`ifndef NORMALIZED_KRONECKER_PRODUCT_ASSERT_SVH
`define NORMALIZED_KRONECKER_PRODUCT_ASSERT_SVH

// Same-cycle implication
`define NKP_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nkp assertion failed");

// Next-cycle implication
`define NKP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nkp assertion failed");

`endif

FILE: hdl/nkp_pkg.sv
package nkp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_COMPONENTS_DEF = 3;
  localparam int MAX_DIM_DEF        = 8;
  localparam int FRAC_BITS_DEF      = 16;

  // Fixed field widths
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 9;
  localparam int TRACE_W    = 40;
  localparam int MAG_W      = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_THIRD  = 3'd5;

  // Function codes and result status
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH    = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD_RD  = 5'd2;
  localparam logic [OP_W-1:0] OP_LOAD_WR  = 5'd3;
  localparam logic [OP_W-1:0] OP_TOTAL    = 5'd4;
  localparam logic [OP_W-1:0] OP_CHECK    = 5'd5;
  localparam logic [OP_W-1:0] OP_DROW_GO  = 5'd6;
  localparam logic [OP_W-1:0] OP_DROW_END = 5'd7;
  localparam logic [OP_W-1:0] OP_DCOL_GO  = 5'd8;
  localparam logic [OP_W-1:0] OP_DCOL_END = 5'd9;
  localparam logic [OP_W-1:0] OP_ELEM_RD  = 5'd10;
  localparam logic [OP_W-1:0] OP_ELEM_ABS = 5'd11;
  localparam logic [OP_W-1:0] OP_NORM_GO  = 5'd12;
  localparam logic [OP_W-1:0] OP_NORM_END = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL      = 5'd14;
  localparam logic [OP_W-1:0] OP_UPD      = 5'd15;
  localparam logic [OP_W-1:0] OP_SCALE    = 5'd16;
  localparam logic [OP_W-1:0] OP_EMIT     = 5'd17;

  typedef struct packed {
    logic              func;
    logic [1:0]        component;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic signed [VAL_W-1:0] element_value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic        normalize_enable;
    logic [31:0] scale_factor;
    logic [1:0]  component_count;
    logic [3:0]  dim_first;
    logic [3:0]  dim_second;
    logic [3:0]  dim_third;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic ld_ok;
    logic k_last;
    logic k_zero;
    logic range_err;
    logic norm_k;
    logic normalize;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/nkp_div.sv
// Restoring divider, one quotient bit per cycle
module nkp_div #(
  parameter int NUM_W   = 60,
  parameter int DEN_W   = 40,
  parameter int SHORT_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             short_mode,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rsh;
  logic             ge;

  assign rsh = {rem, quo[NUM_W-1]};
  assign ge  = rsh >= {1'b0, den_q};

  // Busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= short_mode ? CNT_W'(SHORT_W) : CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift-subtract datapath; a short divide starts with the dividend left-aligned
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= short_mode ? (num << (NUM_W - SHORT_W)) : num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(rsh - {1'b0, den_q}) : rsh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/nkp_dp.sv
// Datapath: element store, traces, index split, magnitude product, result register
module nkp_dp #(
  parameter int MAX_COMPONENTS = nkp_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIM        = nkp_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS      = nkp_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  nkp_pkg::cfg_t  cfg,
  input  nkp_pkg::in_t   item,
  input  nkp_pkg::cmd_t  cmd,
  output nkp_pkg::sts_t  sts,
  input  logic           out_stall,
  output logic           out_valid,
  output nkp_pkg::out_t  out_data
);

  localparam int VAL_W   = nkp_pkg::VAL_W;
  localparam int IDX_W   = nkp_pkg::IDX_W;
  localparam int TRACE_W = nkp_pkg::TRACE_W;
  localparam int MAG_W   = nkp_pkg::MAG_W;
  localparam int KW      = $clog2(MAX_COMPONENTS);
  localparam int CW      = $clog2(MAX_COMPONENTS + 1);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int DI_W    = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_COMPONENTS * MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int TOT_W   = DIM_W * MAX_COMPONENTS;
  localparam int MD_W    = VAL_W + DIM_W;
  localparam int NUM_W   = MD_W + FRAC_BITS;
  localparam int PROD_W  = 2 * MAG_W;
  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << VAL_W;
  localparam logic [MAG_W-1:0] ONE     = MAG_W'(1) << FRAC_BITS;

  logic [nkp_pkg::OP_W-1:0] op;
  assign op = cmd.op;

  // Latched item
  logic             func_q;
  logic [1:0]       comp_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic signed [VAL_W-1:0] val_q;

  // Read working state
  logic [KW-1:0]    k;
  logic [TOT_W-1:0] total;
  logic [IDX_W-1:0] r_q, c_q;
  logic [DI_W-1:0]  rd [MAX_COMPONENTS];
  logic [DI_W-1:0]  cd [MAX_COMPONENTS];
  logic [MAG_W-1:0] mag, fac;
  logic [MD_W-1:0]  md;
  logic [PROD_W-1:0] prod;
  logic             neg, big, zero;

  // Active count and dimension of component k
  logic [CW-1:0]    cnt;
  logic [3:0]       draw;
  logic [DIM_W-1:0] dk;

  always_comb begin
    if (cfg.component_count == 2'd0) begin
      cnt = CW'(1);
    end else if (int'(cfg.component_count) > MAX_COMPONENTS) begin
      cnt = CW'(MAX_COMPONENTS);
    end else begin
      cnt = CW'(cfg.component_count);
    end
  end

  always_comb begin
    if (int'(k) == 0) begin
      draw = cfg.dim_first;
    end else if (int'(k) == 1) begin
      draw = cfg.dim_second;
    end else if (int'(k) == 2) begin
      draw = cfg.dim_third;
    end else begin
      draw = 4'd1;
    end
    if (draw == 4'd0) begin
      dk = DIM_W'(1);
    end else if (int'(draw) > MAX_DIM) begin
      dk = DIM_W'(MAX_DIM);
    end else begin
      dk = DIM_W'(draw);
    end
  end

  // Store addressing
  logic          ld_ok;
  logic [AW-1:0] ld_addr, el_addr, mem_addr;

  assign ld_ok = (int'(comp_q) < MAX_COMPONENTS) && (int'(row_q) < MAX_DIM)
              && (int'(col_q) < MAX_DIM);
  assign ld_addr = AW'(int'(comp_q) * MAX_DIM * MAX_DIM + int'(row_q) * MAX_DIM
                       + int'(col_q));
  assign el_addr = AW'(int'(k) * MAX_DIM * MAX_DIM + int'(rd[k]) * MAX_DIM
                       + int'(cd[k]));
  assign mem_addr = (op == nkp_pkg::OP_ELEM_RD) ? el_addr : ld_addr;

  // Element store with per-entry valid bits
  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [VAL_W-1:0] mem_q;
  logic             vld_q;
  logic signed [VAL_W-1:0] rdat;
  logic             wr_en;

  assign wr_en = (op == nkp_pkg::OP_LOAD_WR) && ld_ok;
  assign rdat  = vld_q ? $signed(mem_q) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ld_addr] <= val_q;
    end
    mem_q <= mem[mem_addr];
    vld_q <= vld[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[ld_addr] <= 1'b1;
    end
  end

  // Diagonal traces
  logic signed [TRACE_W-1:0] trace [MAX_COMPONENTS];
  logic [KW-1:0]             tidx;
  logic signed [TRACE_W-1:0] tr_sel;

  assign tidx   = (op == nkp_pkg::OP_LOAD_WR) ? KW'(comp_q) : k;
  assign tr_sel = trace[tidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        trace[i] <= '0;
      end
    end else if (wr_en && (row_q == col_q)) begin
      trace[tidx] <= tr_sel + TRACE_W'(val_q) - TRACE_W'(rdat);
    end
  end

  // Shared divider: index split and normalizing divide
  logic              div_start, div_short, div_busy;
  logic [NUM_W-1:0]  div_num, div_quo;
  logic [TRACE_W-1:0] div_den, div_rem;

  assign div_start = (op == nkp_pkg::OP_DROW_GO) || (op == nkp_pkg::OP_DCOL_GO)
                  || (op == nkp_pkg::OP_NORM_GO);
  assign div_short = (op != nkp_pkg::OP_NORM_GO);

  always_comb begin
    if (op == nkp_pkg::OP_DROW_GO) begin
      div_num = NUM_W'(r_q);
      div_den = TRACE_W'(dk);
    end else if (op == nkp_pkg::OP_DCOL_GO) begin
      div_num = NUM_W'(c_q);
      div_den = TRACE_W'(dk);
    end else begin
      div_num = {md, {FRAC_BITS{1'b0}}};
      div_den = tr_sel;
    end
  end

  nkp_div #(
    .NUM_W   (NUM_W),
    .DEN_W   (TRACE_W),
    .SHORT_W (IDX_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .short_mode (div_short),
    .num        (div_num),
    .den        (div_den),
    .busy       (div_busy),
    .quo        (div_quo),
    .rem        (div_rem)
  );

  // Arithmetic helpers
  logic [TOT_W+DIM_W-1:0] tot_prod;
  logic [MAG_W-1:0]       mabs;
  logic [MD_W-1:0]        md_prod;
  logic [PROD_W-1:0]      prod_sh;
  logic                   range_err;

  assign tot_prod  = total * dk;
  assign mabs      = rdat[VAL_W-1] ? (MAG_W'(0) - MAG_W'(rdat)) : MAG_W'(rdat);
  assign md_prod   = mabs * dk;
  // magnitude product wraps at 64 bits before the fraction shift
  assign prod_sh   = PROD_W'(prod[2*VAL_W-1:0] >> FRAC_BITS);
  assign range_err = (row_q >= total) || (col_q >= total);

  // Working registers, stepped by the controller
  always_ff @(posedge clk) begin
    case (op)
      nkp_pkg::OP_LATCH: begin
        func_q <= item.func;
        comp_q <= item.component;
        row_q  <= item.row;
        col_q  <= item.col;
        val_q  <= item.element_value;
        r_q    <= item.row;
        c_q    <= item.col;
        k      <= '0;
        total  <= TOT_W'(1);
        mag    <= ONE;
        neg    <= 1'b0;
        big    <= 1'b0;
        zero   <= 1'b0;
      end
      nkp_pkg::OP_TOTAL: begin
        total <= tot_prod[TOT_W-1:0];
        k     <= k + KW'(1);
      end
      nkp_pkg::OP_CHECK: begin
        k <= KW'(cnt - CW'(1));
      end
      nkp_pkg::OP_DROW_END: begin
        rd[k] <= div_rem[DI_W-1:0];
        r_q   <= div_quo[IDX_W-1:0];
      end
      nkp_pkg::OP_DCOL_END: begin
        cd[k] <= div_rem[DI_W-1:0];
        c_q   <= div_quo[IDX_W-1:0];
        if (k != '0) begin
          k <= k - KW'(1);
        end
      end
      nkp_pkg::OP_ELEM_ABS: begin
        neg <= neg ^ rdat[VAL_W-1];
        fac <= mabs;
        md  <= md_prod;
      end
      nkp_pkg::OP_NORM_END: begin
        if (div_quo > NUM_W'(MAG_CAP)) begin
          fac <= MAG_CAP;
          big <= 1'b1;
        end else begin
          fac <= div_quo[MAG_W-1:0];
        end
      end
      nkp_pkg::OP_MUL: begin
        prod <= mag * fac;
      end
      nkp_pkg::OP_UPD: begin
        if (prod_sh > PROD_W'(MAG_CAP)) begin
          mag <= MAG_CAP;
          big <= 1'b1;
        end else begin
          mag <= prod_sh[MAG_W-1:0];
        end
        if (fac == '0) begin
          zero <= 1'b1;
        end
        k <= k + KW'(1);
      end
      nkp_pkg::OP_SCALE: begin
        fac <= MAG_W'(cfg.scale_factor);
      end
      default: begin
      end
    endcase
  end

  // Final result
  nkp_pkg::out_t    res;
  logic [MAG_W-1:0] limit;

  always_comb begin
    limit = neg ? MAG_W'(33'h080000000) : MAG_W'(33'h07FFFFFFF);
    if (range_err) begin
      res.product_value = '0;
      res.status        = nkp_pkg::ST_RANGE;
    end else if (zero) begin
      res.product_value = '0;
      res.status        = nkp_pkg::ST_OK;
    end else if (big || (mag > limit)) begin
      res.product_value = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      res.status        = nkp_pkg::ST_SAT;
    end else begin
      res.product_value = neg ? $signed(32'(0) - mag[VAL_W-1:0]) : $signed(mag[VAL_W-1:0]);
      res.status        = nkp_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == nkp_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == nkp_pkg::OP_EMIT) begin
      out_data <= res;
    end
  end

  // Status to the controller
  always_comb begin
    sts.is_read   = (func_q == nkp_pkg::FUNC_READ);
    sts.ld_ok     = ld_ok;
    sts.k_last    = (CW'(k) + CW'(1)) == cnt;
    sts.k_zero    = (k == '0);
    sts.range_err = range_err;
    sts.norm_k    = cfg.normalize_enable && !tr_sel[TRACE_W-1] && (tr_sel != '0);
    sts.normalize = cfg.normalize_enable;
    sts.div_busy  = div_busy;
    sts.out_busy  = out_valid && out_stall;
  end

endmodule

FILE: hdl/nkp_ctrl.sv
// Controller: sequences loads and reads through the datapath
module nkp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  nkp_pkg::sts_t sts,
  output nkp_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_LD_RD  = 5'd2;
  localparam logic [4:0] S_LD_WR  = 5'd3;
  localparam logic [4:0] S_TOT    = 5'd4;
  localparam logic [4:0] S_CHK    = 5'd5;
  localparam logic [4:0] S_RNG    = 5'd6;
  localparam logic [4:0] S_DR_GO  = 5'd7;
  localparam logic [4:0] S_DR_WT  = 5'd8;
  localparam logic [4:0] S_DC_GO  = 5'd9;
  localparam logic [4:0] S_DC_WT  = 5'd10;
  localparam logic [4:0] S_E_RD   = 5'd11;
  localparam logic [4:0] S_E_ABS  = 5'd12;
  localparam logic [4:0] S_N_GO   = 5'd13;
  localparam logic [4:0] S_N_WT   = 5'd14;
  localparam logic [4:0] S_MUL    = 5'd15;
  localparam logic [4:0] S_UPD    = 5'd16;
  localparam logic [4:0] S_SC     = 5'd17;
  localparam logic [4:0] S_GMUL   = 5'd18;
  localparam logic [4:0] S_GUPD   = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  logic [4:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = nkp_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = nkp_pkg::OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = sts.is_read ? S_TOT : S_LD_RD;
      end
      S_LD_RD: begin
        cmd.op     = nkp_pkg::OP_LOAD_RD;
        state_next = sts.ld_ok ? S_LD_WR : S_IDLE;
      end
      S_LD_WR: begin
        cmd.op     = nkp_pkg::OP_LOAD_WR;
        state_next = S_IDLE;
      end
      S_TOT: begin
        cmd.op = nkp_pkg::OP_TOTAL;
        if (sts.k_last) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.op     = nkp_pkg::OP_CHECK;
        state_next = S_RNG;
      end
      S_RNG: begin
        state_next = sts.range_err ? S_DONE : S_DR_GO;
      end
      S_DR_GO: begin
        cmd.op     = nkp_pkg::OP_DROW_GO;
        state_next = S_DR_WT;
      end
      S_DR_WT: begin
        if (!sts.div_busy) begin
          cmd.op     = nkp_pkg::OP_DROW_END;
          state_next = S_DC_GO;
        end
      end
      S_DC_GO: begin
        cmd.op     = nkp_pkg::OP_DCOL_GO;
        state_next = S_DC_WT;
      end
      S_DC_WT: begin
        if (!sts.div_busy) begin
          cmd.op     = nkp_pkg::OP_DCOL_END;
          state_next = sts.k_zero ? S_E_RD : S_DR_GO;
        end
      end
      S_E_RD: begin
        cmd.op     = nkp_pkg::OP_ELEM_RD;
        state_next = S_E_ABS;
      end
      S_E_ABS: begin
        cmd.op     = nkp_pkg::OP_ELEM_ABS;
        state_next = sts.norm_k ? S_N_GO : S_MUL;
      end
      S_N_GO: begin
        cmd.op     = nkp_pkg::OP_NORM_GO;
        state_next = S_N_WT;
      end
      S_N_WT: begin
        if (!sts.div_busy) begin
          cmd.op     = nkp_pkg::OP_NORM_END;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = nkp_pkg::OP_MUL;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op = nkp_pkg::OP_UPD;
        if (!sts.k_last) begin
          state_next = S_E_RD;
        end else if (sts.normalize) begin
          state_next = S_SC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SC: begin
        cmd.op     = nkp_pkg::OP_SCALE;
        state_next = S_GMUL;
      end
      S_GMUL: begin
        cmd.op     = nkp_pkg::OP_MUL;
        state_next = S_GUPD;
      end
      S_GUPD: begin
        cmd.op     = nkp_pkg::OP_UPD;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op     = nkp_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/normalized_kronecker_product.sv
// Normalized Kronecker product reader. Loads write one component element (no
// result beat); a load that falls outside the store writes nothing. Reads return
// one beat with the saturated Q16.16 product entry and a status code. For each
// active component the index split runs two 9-step divides, a component
// normalized by a positive trace adds a normalizing divide, and a global scale
// follows when normalization is on. An out-of-range read skips the split. The
// shared serial divider produces one quotient bit a cycle. One item is in work
// at a time; a finished result waits in the output register while the next item
// is accepted.
`include "normalized_kronecker_product_assert.svh"

module normalized_kronecker_product #(
  parameter int MAX_COMPONENTS = nkp_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIM        = nkp_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS      = nkp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nkp_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nkp_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [nkp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nkp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  nkp_pkg::cfg_t cfg;
  nkp_pkg::cmd_t cmd;
  nkp_pkg::sts_t sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normalize_enable <= 1'b0;
      cfg.scale_factor     <= 32'd1 << FRAC_BITS;
      cfg.component_count  <= 2'd1;
      cfg.dim_first        <= 4'd1;
      cfg.dim_second       <= 4'd1;
      cfg.dim_third        <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        nkp_pkg::REG_NORMALIZE:  cfg.normalize_enable <= cfg_data[0];
        nkp_pkg::REG_SCALE:      cfg.scale_factor     <= cfg_data;
        nkp_pkg::REG_COUNT:      cfg.component_count  <= cfg_data[1:0];
        nkp_pkg::REG_DIM_FIRST:  cfg.dim_first        <= cfg_data[3:0];
        nkp_pkg::REG_DIM_SECOND: cfg.dim_second       <= cfg_data[3:0];
        nkp_pkg::REG_DIM_THIRD:  cfg.dim_third        <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  nkp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nkp_dp #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_DIM        (MAX_DIM),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `NKP_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `NKP_ASSERT_IMP(a_div_stall, sts.div_busy, in_stall)
  `NKP_ASSERT_IMP(a_range_zero, out_valid && out_data.status == nkp_pkg::ST_RANGE, out_data.product_value == 0)
  `NKP_ASSERT_IMP(a_sat_value, out_valid && out_data.status == nkp_pkg::ST_SAT, out_data.product_value == 32'h7FFFFFFF || out_data.product_value == 32'h80000000)

endmodule

FILE: tb/sv/normalized_kronecker_product_tb.sv
`timescale 1ns / 100ps

// Predicts the product entries and checks each result beat against them
class product_scoreboard;
  localparam int NCOMP = nkp_pkg::MAX_COMPONENTS_DEF;
  localparam int NDIM  = nkp_pkg::MAX_DIM_DEF;
  localparam int FRAC  = nkp_pkg::FRAC_BITS_DEF;

  nkp_pkg::cfg_t regs;
  longint elems [NCOMP][NDIM][NDIM];
  longint traces [NCOMP];
  nkp_pkg::out_t pending_entries [$];
  int     errors;

  function new();
    regs.normalize_enable = 1'b0;
    regs.scale_factor     = 32'd1 << FRAC;
    regs.component_count  = 2'd1;
    regs.dim_first        = 4'd1;
    regs.dim_second       = 4'd1;
    regs.dim_third        = 4'd1;
    foreach (elems[k, r, c]) elems[k][r][c] = 0;
    foreach (traces[k]) traces[k] = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [nkp_pkg::CFG_IDX_W-1:0] idx,
                          logic [nkp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      nkp_pkg::REG_NORMALIZE:  regs.normalize_enable = val[0];
      nkp_pkg::REG_SCALE:      regs.scale_factor     = val;
      nkp_pkg::REG_COUNT:      regs.component_count  = val[1:0];
      nkp_pkg::REG_DIM_FIRST:  regs.dim_first        = val[3:0];
      nkp_pkg::REG_DIM_SECOND: regs.dim_second       = val[3:0];
      nkp_pkg::REG_DIM_THIRD:  regs.dim_third        = val[3:0];
      default: ;
    endcase
  endfunction

  function int active_count();
    int n;
    n = regs.component_count;
    if (n == 0) n = 1;
    if (n > NCOMP) n = NCOMP;
    return n;
  endfunction

  function int active_dim(int k);
    int d;
    d = (k == 0) ? regs.dim_first : (k == 1) ? regs.dim_second : regs.dim_third;
    if (d == 0) d = 1;
    if (d > NDIM) d = NDIM;
    return d;
  endfunction

  function int span();
    int s;
    s = 1;
    for (int k = 0; k < active_count(); k++) s *= active_dim(k);
    return s;
  endfunction

  // Magnitudes are held at 2^32, overflow is sticky
  function bit [63:0] cap(bit [63:0] m, inout bit big);
    if (m > 64'h1_0000_0000) begin
      big = 1'b1;
      return 64'h1_0000_0000;
    end
    return m;
  endfunction

  function nkp_pkg::out_t product_entry(nkp_pkg::in_t b);
    nkp_pkg::out_t res;
    int        n, r, c, d;
    int        rd [NCOMP];
    int        cd [NCOMP];
    bit [63:0] mag, m, lim;
    bit        neg, big, zero;
    longint    e, t;
    n = active_count();
    res.product_value = '0;
    res.status = nkp_pkg::ST_RANGE;
    if (b.row >= span() || b.col >= span()) return res;
    r = b.row;
    c = b.col;
    // mixed-radix split, last component is the least significant digit
    for (int k = n - 1; k >= 0; k--) begin
      d = active_dim(k);
      rd[k] = r % d;
      r = r / d;
      cd[k] = c % d;
      c = c / d;
    end
    mag = 64'd1 << FRAC;
    neg = 1'b0;
    big = 1'b0;
    zero = 1'b0;
    for (int k = 0; k < n; k++) begin
      d = active_dim(k);
      e = elems[k][rd[k]][cd[k]];
      t = traces[k];
      m = (e < 0) ? 64'(-e) : 64'(e);
      if (e < 0) neg = !neg;
      if (regs.normalize_enable && t > 0) m = ((m * 64'(d)) << FRAC) / 64'(t);
      m = cap(m, big);
      if (m == 0) zero = 1'b1;
      mag = cap((mag * m) >> FRAC, big);
    end
    if (regs.normalize_enable) begin
      if (regs.scale_factor == 0) zero = 1'b1;
      mag = cap((mag * 64'(regs.scale_factor)) >> FRAC, big);
    end
    res.status = nkp_pkg::ST_OK;
    if (zero) return res;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (big || mag > lim) begin
      res.product_value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      res.status = nkp_pkg::ST_SAT;
      return res;
    end
    res.product_value = neg ? 32'(-mag) : 32'(mag);
    return res;
  endfunction

  // Accepted input beat: loads update the store, reads queue a prediction
  function void note_input(nkp_pkg::in_t b);
    longint v;
    if (b.func == nkp_pkg::FUNC_READ) begin
      pending_entries.insert(pending_entries.size(), product_entry(b));
    end else if (b.component < NCOMP && b.row < NDIM && b.col < NDIM) begin
      v = longint'(b.element_value);
      if (b.row == b.col) traces[b.component] += v - elems[b.component][b.row][b.col];
      elems[b.component][b.row][b.col] = v;
    end
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(nkp_pkg::out_t got);
    nkp_pkg::out_t want;
    if (pending_entries.size() == 0) begin
      report($sformatf("unexpected result beat value=%h status=%0d",
                       got.product_value, got.status));
      return;
    end
    want = pending_entries.pop_front();
    if (got.product_value !== want.product_value)
      report($sformatf("product_value got %h want %h", got.product_value,
                       want.product_value));
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
  endtask
endclass

module normalized_kronecker_product_tb;
  localparam int SETTLE = 400;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  nkp_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_stall;
  nkp_pkg::out_t                  out_data;
  logic                           cfg_we;
  logic [nkp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nkp_pkg::CFG_DATA_W-1:0] cfg_data;

  product_scoreboard sb;
  bit     quiet;
  longint cycles = 0;

  normalized_kronecker_product DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("normalized_kronecker_product_tb: FAIL");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall = !quiet && ($urandom_range(99) < 13);
  end

  // Result beats
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  task send_beat(nkp_pkg::in_t b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
  endtask

  // Wait for every expected result, then let a trailing load finish
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [nkp_pkg::CFG_IDX_W-1:0] idx, logic [nkp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_regs(bit norm, logic [31:0] scale, logic [1:0] cnt,
                logic [3:0] d0, logic [3:0] d1, logic [3:0] d2);
    write_reg(nkp_pkg::REG_NORMALIZE, 32'(norm));
    write_reg(nkp_pkg::REG_SCALE, scale);
    write_reg(nkp_pkg::REG_COUNT, 32'(cnt));
    write_reg(nkp_pkg::REG_DIM_FIRST, 32'(d0));
    write_reg(nkp_pkg::REG_DIM_SECOND, 32'(d1));
    write_reg(nkp_pkg::REG_DIM_THIRD, 32'(d2));
  endtask

  function logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 32'h0;
    if (sel < 20) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (sel < 75) begin
      pick_value = 32'($urandom_range(32'h4_0000));
      if ($urandom_range(1)) pick_value = -pick_value;
      return pick_value;
    end
    return $urandom;
  endfunction

  function nkp_pkg::in_t load_beat(int k, int r, int c, logic [31:0] v);
    nkp_pkg::in_t b;
    b.func = nkp_pkg::FUNC_LOAD;
    b.component = 2'(k);
    b.row = 9'(r);
    b.col = 9'(c);
    b.element_value = v;
    return b;
  endfunction

  function nkp_pkg::in_t read_beat(int r, int c);
    nkp_pkg::in_t b;
    b = '0;
    b.func = nkp_pkg::FUNC_READ;
    b.component = 2'($urandom_range(3));
    b.row = 9'(r);
    b.col = 9'(c);
    b.element_value = $urandom;
    return b;
  endfunction

  function nkp_pkg::in_t random_beat();
    int k, s;
    s = sb.span();
    if ($urandom_range(99) < 40) begin
      if ($urandom_range(99) < 8)
        return load_beat($urandom_range(3), $urandom_range(511), $urandom_range(511),
                         $urandom);
      k = $urandom_range(sb.active_count() - 1);
      return load_beat(k, $urandom_range(sb.active_dim(k) - 1),
                       $urandom_range(sb.active_dim(k) - 1), pick_value());
    end
    if ($urandom_range(99) < 12) return read_beat($urandom_range(511), $urandom_range(511));
    return read_beat($urandom_range(s - 1), $urandom_range(s - 1));
  endfunction

  initial begin
    int items;
    sb = new();
    quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset defaults, ignored loads, extremes, range errors
    send_beat(read_beat(0, 0));
    send_beat(load_beat(0, 0, 0, 32'h0001_0000));
    send_beat(read_beat(0, 0));
    send_beat(read_beat(1, 0));
    send_beat(read_beat(0, 511));
    send_beat(load_beat(3, 0, 0, 32'h0002_0000));
    send_beat(load_beat(0, 8, 8, 32'h0002_0000));
    send_beat(load_beat(0, 511, 0, 32'h0002_0000));
    send_beat(read_beat(0, 0));
    send_beat(load_beat(0, 0, 0, 32'h7FFF_FFFF));
    send_beat(read_beat(0, 0));
    send_beat(load_beat(0, 0, 0, 32'h8000_0000));
    send_beat(read_beat(0, 0));
    drain();
    // all three components at full size, normalized, largest scale
    set_regs(1'b1, 32'hFFFF_FFFF, 2'd3, 4'd8, 4'd8, 4'd8);
    send_beat(load_beat(1, 7, 7, 32'h0000_8000));
    send_beat(load_beat(2, 3, 3, 32'hFFFF_0000));
    send_beat(load_beat(2, 0, 5, 32'h0003_0000));
    send_beat(read_beat(0, 0));
    send_beat(read_beat(511, 511));
    send_beat(read_beat(511, 7));
    drain();
    // zero registers clamp up to one, zero scale forces zero
    set_regs(1'b1, 32'h0, 2'd0, 4'd0, 4'd15, 4'd15);
    send_beat(read_beat(0, 0));
    send_beat(read_beat(0, 1));
    drain();

    // Random phases: seed the diagonals, then mixed loads and reads
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(1'b0, 32'h0001_0000, 2'd3, 4'd2, 4'd3, 4'd4);
        1: set_regs(1'b1, 32'h0001_0000, 2'd2, 4'd8, 4'd8, 4'd1);
        default: set_regs(1'($urandom_range(1)), $urandom_range(99) < 20 ? $urandom :
                          32'($urandom_range(32'h3_0000)), 2'($urandom_range(3)),
                          4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
      endcase
      quiet = (ph == 3);
      for (int k = 0; k < sb.active_count(); k++)
        for (int d = 0; d < sb.active_dim(k); d++)
          send_beat(load_beat(k, d, d, $urandom_range(99) < 80 ?
                              32'($urandom_range(32'h2_0000, 32'h4000)) : pick_value()));
      items = 0;
      while (items < 180) begin
        send_beat(random_beat());
        items++;
      end
      drain();
      quiet = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("normalized_kronecker_product_tb: PASS");
    end else begin
      $display("normalized_kronecker_product_tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/nkp_pkg.sv
hdl/nkp_div.sv
hdl/nkp_dp.sv
hdl/nkp_ctrl.sv
hdl/normalized_kronecker_product.sv
tb/sv/normalized_kronecker_product_tb.sv
